### rtl/pfba_pkg.sv
// ----------------------------------------------------------------------------
// pfba_pkg
// Shared types, sizes, codes and helpers of the page frame bitmap allocator.
// ----------------------------------------------------------------------------
package pfba_pkg;

	localparam int WORDS_PER_REGION = 64;
	localparam int NUM_REGIONS      = 3;
	localparam int DEPTH            = NUM_REGIONS * WORDS_PER_REGION;
	localparam int ADDR_W           = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int WIDX_W           = (WORDS_PER_REGION > 1) ? $clog2(WORDS_PER_REGION) : 1;

	localparam int CFG_REGIONS = 3;
	localparam int WORD_W      = 64;
	localparam int BIT_W       = 6;
	localparam int FRAME_W     = 28;
	localparam int WCNT_W      = 7;
	localparam int RCNT_W      = 2;
	localparam int RES_W       = 13;
	localparam int FREE_W      = 13;
	localparam int TOTAL_W     = 14;
	localparam int REG_W       = 2;
	localparam int OP_W        = 2;
	localparam int ST_W        = 2;
	localparam int CFG_IDX_W   = 3;

	localparam logic [WORD_W-1:0]  FULL_WORD       = '1;
	localparam logic [FREE_W-1:0]  REGION_FREE_MAX = '1;
	localparam logic [TOTAL_W-1:0] TOTAL_FREE_MAX  = '1;
	localparam logic [FRAME_W-1:0] BASE0_RESET     = FRAME_W'(256);

	localparam logic [OP_W-1:0] OP_ALLOC   = 2'd0;
	localparam logic [OP_W-1:0] OP_RELEASE = 2'd1;
	localparam logic [OP_W-1:0] OP_INIT    = 2'd2;
	localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

	localparam logic [ST_W-1:0] ST_OK      = 2'd0;
	localparam logic [ST_W-1:0] ST_NOFREE  = 2'd1;
	localparam logic [ST_W-1:0] ST_OUTSIDE = 2'd2;
	localparam logic [ST_W-1:0] ST_REFUSED = 2'd3;

	localparam logic [CFG_IDX_W-1:0] CFG_BASE0    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WORDS0   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE1    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WORDS1   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE2    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_WORDS2   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] CFG_RCOUNT   = 3'd6;
	localparam logic [CFG_IDX_W-1:0] CFG_RESERVED = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]    opcode;
		logic [FRAME_W-1:0] release_frame;
	} pfba_req_t;

	typedef struct packed {
		logic [ST_W-1:0]    status;
		logic [FRAME_W-1:0] frame_number;
		logic [REG_W-1:0]   region_index;
		logic [TOTAL_W-1:0] total_free;
	} pfba_rsp_t;

	typedef struct packed {
		logic [CFG_REGIONS-1:0][FRAME_W-1:0] base_frame;
		logic [CFG_REGIONS-1:0][WCNT_W-1:0]  words;
		logic [RCNT_W-1:0]                   region_count;
		logic [RES_W-1:0]                    reserved_frames;
	} pfba_cfg_t;

	function automatic logic [WCNT_W-1:0] words_eff(input logic [WCNT_W-1:0] w);
		logic [WCNT_W-1:0] r;
		r = w;
		if (int'(w) > WORDS_PER_REGION) r = WCNT_W'(WORDS_PER_REGION);
		return r;
	endfunction

	function automatic logic [ADDR_W-1:0] word_addr(input logic [REG_W-1:0] r,
			input logic [WIDX_W-1:0] w);
		return ADDR_W'(int'(r) * WORDS_PER_REGION + int'(w));
	endfunction

endpackage

### rtl/pfba_bitmap_ram.sv
// ----------------------------------------------------------------------------
// pfba_bitmap_ram
// Simple dual port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module pfba_bitmap_ram #(
	parameter int DATA_W = 64,
	parameter int DEPTH  = 192,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/pfba_engine.sv
// ----------------------------------------------------------------------------
// pfba_engine
// Request sequencer: first-fit word scan, release check and bitmap
// initialize, read-modify-write on the bitmap RAM, free counters.
// ----------------------------------------------------------------------------
module pfba_engine (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  pfba_pkg::pfba_req_t                req,
	input  pfba_pkg::pfba_cfg_t                cfg,
	output logic                               idle,
	output logic                               res_valid,
	output pfba_pkg::pfba_rsp_t                res,
	output logic                               mem_we,
	output logic [pfba_pkg::ADDR_W-1:0]        mem_waddr,
	output logic [pfba_pkg::WORD_W-1:0]        mem_wdata,
	output logic                               mem_re,
	output logic [pfba_pkg::ADDR_W-1:0]        mem_raddr,
	input  logic [pfba_pkg::WORD_W-1:0]        mem_rdata
);
	import pfba_pkg::*;

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_SCAN  = 3'd1;
	localparam logic [2:0] S_RFIND = 3'd2;
	localparam logic [2:0] S_RRD   = 3'd3;
	localparam logic [2:0] S_RCHK  = 3'd4;
	localparam logic [2:0] S_INIT  = 3'd5;

	logic [2:0]                         state_q, state_d;
	logic [REG_W-1:0]                   ir_q, ir_d;
	logic [WIDX_W-1:0]                  iw_q, iw_d;
	logic                               iss_more_q, iss_more_d;
	logic                               ck_vld_s1, ck_vld_d;
	logic [REG_W-1:0]                   ck_r_s1;
	logic [WIDX_W-1:0]                  ck_w_s1;
	logic                               rvld_s1;
	logic [DEPTH-1:0]                   valid_q;
	logic                               init_clr;
	logic [NUM_REGIONS-1:0][FREE_W-1:0] free_q, free_d, free_init;
	logic [TOTAL_W-1:0]                 total_q, total_d, total_init;
	logic [FRAME_W-1:0]                 frame_q, frame_d;
	logic [REG_W-1:0]                   rel_r_q, rel_r_d;
	logic [FREE_W-1:0]                  rel_off_q, rel_off_d;
	logic [WCNT_W-1:0]                  k_q, k_d;

	logic [REG_W-1:0]                   n_act;
	logic [CFG_REGIONS-1:0][WCNT_W-1:0] weff;
	logic [CFG_REGIONS-1:0][FREE_W-1:0] cap;
	logic [NUM_REGIONS-1:0]             active;
	logic [FREE_W-1:0]                  res_lim;
	logic [REG_W-1:0]                   first_r, nxt_r, m_r;
	logic                               first_ok, nxt_ok, m_ok;
	logic [FREE_W-1:0]                  m_off;
	logic [WORD_W-1:0]                  word_s1;
	logic [BIT_W-1:0]                   fb;
	logic                               found;

	// geometry seen through the saturation rules
	always_comb begin
		n_act = (int'(cfg.region_count) > NUM_REGIONS) ? REG_W'(NUM_REGIONS)
			: cfg.region_count;
		for (int r = 0; r < CFG_REGIONS; r++) begin
			weff[r] = words_eff(cfg.words[r]);
			cap[r]  = {weff[r], {BIT_W{1'b0}}};
		end
		for (int r = 0; r < NUM_REGIONS; r++) begin
			active[r] = (r < int'(n_act)) && (weff[r] != '0);
		end
		if (n_act == '0) begin
			res_lim = '0;
		end else begin
			res_lim = (cfg.reserved_frames > cap[0]) ? cap[0] : cfg.reserved_frames;
		end
	end

	// region walk for the scan
	always_comb begin
		first_r  = '0;
		first_ok = 1'b0;
		nxt_r    = '0;
		nxt_ok   = 1'b0;
		for (int r = NUM_REGIONS - 1; r >= 0; r--) begin
			if (active[r]) begin
				first_r  = REG_W'(r);
				first_ok = 1'b1;
			end
			if (active[r] && (r > int'(ir_q))) begin
				nxt_r  = REG_W'(r);
				nxt_ok = 1'b1;
			end
		end
	end

	// release range match, lowest region wins
	always_comb begin : rel_match
		logic [FRAME_W:0] diff;
		m_ok  = 1'b0;
		m_r   = '0;
		m_off = '0;
		for (int r = NUM_REGIONS - 1; r >= 0; r--) begin
			diff = {1'b0, frame_q} - {1'b0, cfg.base_frame[r]};
			if ((r < int'(n_act)) && !diff[FRAME_W]
					&& (diff[FRAME_W-1:0] < FRAME_W'(cap[r]))) begin
				m_ok  = 1'b1;
				m_r   = REG_W'(r);
				m_off = FREE_W'(diff);
			end
		end
	end

	// free counts after initialize
	always_comb begin : init_counts
		logic [TOTAL_W:0] sum;
		sum = '0;
		for (int r = 0; r < NUM_REGIONS; r++) begin
			free_init[r] = (r < int'(n_act)) ? cap[r] : '0;
		end
		free_init[0] = (free_init[0] > res_lim) ? free_init[0] - res_lim : '0;
		for (int r = 0; r < NUM_REGIONS; r++) begin
			sum = sum + (TOTAL_W + 1)'(free_init[r]);
		end
		total_init = (sum > (TOTAL_W + 1)'(TOTAL_FREE_MAX)) ? TOTAL_FREE_MAX
			: sum[TOTAL_W-1:0];
	end

	// first clear bit of the word under check
	always_comb begin
		word_s1 = rvld_s1 ? mem_rdata : '0;
		fb = '0;
		for (int b = WORD_W - 1; b >= 0; b--) begin
			if (!word_s1[b]) fb = BIT_W'(b);
		end
		found = (state_q == S_SCAN) && ck_vld_s1 && (word_s1 != FULL_WORD);
	end

	always_comb begin
		state_d    = state_q;
		ir_d       = ir_q;
		iw_d       = iw_q;
		iss_more_d = iss_more_q;
		ck_vld_d   = 1'b0;
		k_d        = k_q;
		rel_r_d    = rel_r_q;
		rel_off_d  = rel_off_q;
		frame_d    = frame_q;
		free_d     = free_q;
		total_d    = total_q;
		init_clr   = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = '0;
		mem_we     = 1'b0;
		mem_waddr  = '0;
		mem_wdata  = '0;
		res_valid  = 1'b0;
		res.status       = ST_OK;
		res.frame_number = '0;
		res.region_index = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					frame_d = req.release_frame;
					unique case (req.opcode)
						OP_ALLOC: begin
							ir_d       = first_r;
							iw_d       = '0;
							iss_more_d = first_ok;
							state_d    = S_SCAN;
						end
						OP_RELEASE: begin
							state_d = S_RFIND;
						end
						OP_INIT: begin
							init_clr = 1'b1;
							free_d   = free_init;
							total_d  = total_init;
							k_d      = '0;
							state_d  = S_INIT;
						end
						OP_NOP: begin
							res_valid = 1'b1;
						end
					endcase
				end
			end
			S_SCAN: begin
				if (found) begin
					mem_we    = 1'b1;
					mem_waddr = word_addr(ck_r_s1, ck_w_s1);
					mem_wdata = word_s1 | (WORD_W'(1) << fb);
					if (free_q[ck_r_s1] != '0) free_d[ck_r_s1] = free_q[ck_r_s1] - 1'b1;
					if (total_q != '0) total_d = total_q - 1'b1;
					res_valid        = 1'b1;
					res.frame_number = cfg.base_frame[ck_r_s1] + FRAME_W'({ck_w_s1, fb});
					res.region_index = ck_r_s1;
					state_d          = S_IDLE;
				end else if (!iss_more_q) begin
					res_valid  = 1'b1;
					res.status = ST_NOFREE;
					state_d    = S_IDLE;
				end else begin
					mem_re    = 1'b1;
					mem_raddr = word_addr(ir_q, iw_q);
					ck_vld_d  = 1'b1;
					if ((int'(iw_q) + 1) >= int'(weff[ir_q])) begin
						iw_d = '0;
						if (nxt_ok) begin
							ir_d = nxt_r;
						end else begin
							iss_more_d = 1'b0;
						end
					end else begin
						iw_d = iw_q + 1'b1;
					end
				end
			end
			S_RFIND: begin
				if (m_ok) begin
					rel_r_d   = m_r;
					rel_off_d = m_off;
					state_d   = S_RRD;
				end else begin
					res_valid  = 1'b1;
					res.status = ST_OUTSIDE;
					state_d    = S_IDLE;
				end
			end
			S_RRD: begin
				mem_re    = 1'b1;
				mem_raddr = word_addr(rel_r_q, WIDX_W'(rel_off_q >> BIT_W));
				state_d   = S_RCHK;
			end
			S_RCHK: begin
				res_valid        = 1'b1;
				res.region_index = rel_r_q;
				state_d          = S_IDLE;
				if (((rel_r_q == '0) && (rel_off_q < res_lim))
						|| !word_s1[rel_off_q[BIT_W-1:0]]) begin
					res.status = ST_REFUSED;
				end else begin
					mem_we    = 1'b1;
					mem_waddr = word_addr(rel_r_q, WIDX_W'(rel_off_q >> BIT_W));
					mem_wdata = word_s1 & ~(WORD_W'(1) << rel_off_q[BIT_W-1:0]);
					if (free_q[rel_r_q] != REGION_FREE_MAX) begin
						free_d[rel_r_q] = free_q[rel_r_q] + 1'b1;
					end
					if (total_q != TOTAL_FREE_MAX) total_d = total_q + 1'b1;
				end
			end
			S_INIT: begin
				if ({k_q, {BIT_W{1'b0}}} < res_lim) begin
					mem_we    = 1'b1;
					mem_waddr = word_addr('0, WIDX_W'(k_q));
					mem_wdata = (k_q < res_lim[FREE_W-1:BIT_W]) ? FULL_WORD
						: ((WORD_W'(1) << res_lim[BIT_W-1:0]) - WORD_W'(1));
					k_d = k_q + 1'b1;
				end else begin
					res_valid = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		res.total_free = total_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			iss_more_q <= 1'b0;
			ck_vld_s1  <= 1'b0;
			valid_q    <= '0;
			free_q     <= '0;
			total_q    <= '0;
		end else begin
			state_q    <= state_d;
			iss_more_q <= iss_more_d;
			ck_vld_s1  <= ck_vld_d;
			free_q     <= free_d;
			total_q    <= total_d;
			if (init_clr) begin
				valid_q <= '0;
			end else if (mem_we) begin
				valid_q[mem_waddr] <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		ir_q      <= ir_d;
		iw_q      <= iw_d;
		ck_r_s1   <= ir_q;
		ck_w_s1   <= iw_q;
		rvld_s1   <= valid_q[mem_raddr];
		k_q       <= k_d;
		rel_r_q   <= rel_r_d;
		rel_off_q <= rel_off_d;
		frame_q   <= frame_d;
	end

	assign idle = (state_q == S_IDLE);

endmodule

### rtl/multi_region_page_frame_bitmap_allocator_unit.sv
// ----------------------------------------------------------------------------
// multi_region_page_frame_bitmap_allocator_unit
// First-fit page frame allocator over up to three regions, one used bit per
// frame, bitmap words held in a synchronous RAM.
//
//   channel   signals                          direction  beat taken when
//   request   start, busy, req                 in         start & !busy
//   result    done, rsp                        out        done (one cycle)
//   config    cfg_valid, cfg_ready,            in         cfg_valid & cfg_ready
//             cfg_index, cfg_data
//
// allocate scans the bitmap words first fit, one RAM read per cycle over up to
// 192 words; release reads and checks one word unless the frame lies outside every
// region; initialize writes ceil(reserved/64) words of region 0, reserved clamped to
// region 0; the unused code only answers.
// busy is low again in the cycle the result is shown.
// reset clears the bitmap through per-word valid bits at once: no sweep.
// results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module multi_region_page_frame_bitmap_allocator_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  pfba_pkg::pfba_req_t                 req,
	output logic                                done,
	output pfba_pkg::pfba_rsp_t                 rsp,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [pfba_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pfba_pkg::FRAME_W-1:0]        cfg_data
);
	import pfba_pkg::*;

	pfba_cfg_t          cfg_q;
	logic               idle;
	logic               accept;
	logic               res_valid;
	pfba_rsp_t          res;
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr;
	logic [WORD_W-1:0]  mem_wdata;
	logic               mem_re;
	logic [ADDR_W-1:0]  mem_raddr;
	logic [WORD_W-1:0]  mem_rdata;
	logic               done_q;
	pfba_rsp_t          rsp_q;

	assign cfg_ready = 1'b1;
	assign busy      = !idle;
	assign accept    = start && idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.base_frame[2]   <= '0;
			cfg_q.base_frame[1]   <= '0;
			cfg_q.base_frame[0]   <= BASE0_RESET;
			cfg_q.words           <= '0;
			cfg_q.region_count    <= '0;
			cfg_q.reserved_frames <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_BASE0:    cfg_q.base_frame[0]   <= cfg_data;
				CFG_WORDS0:   cfg_q.words[0]        <= cfg_data[WCNT_W-1:0];
				CFG_BASE1:    cfg_q.base_frame[1]   <= cfg_data;
				CFG_WORDS1:   cfg_q.words[1]        <= cfg_data[WCNT_W-1:0];
				CFG_BASE2:    cfg_q.base_frame[2]   <= cfg_data;
				CFG_WORDS2:   cfg_q.words[2]        <= cfg_data[WCNT_W-1:0];
				CFG_RCOUNT:   cfg_q.region_count    <= cfg_data[RCNT_W-1:0];
				CFG_RESERVED: cfg_q.reserved_frames <= cfg_data[RES_W-1:0];
			endcase
		end
	end

	pfba_engine u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.req       (req),
		.cfg       (cfg_q),
		.idle      (idle),
		.res_valid (res_valid),
		.res       (res),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_re    (mem_re),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	pfba_bitmap_ram #(
		.DATA_W (WORD_W),
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

### rtl/pfba_checker.sv
// ----------------------------------------------------------------------------
// pfba_checker
// Port level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module pfba_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                start,
	input logic                busy,
	input logic                done,
	input pfba_pkg::pfba_rsp_t rsp
);
	import pfba_pkg::*;

	// an accepted beat is either in progress or answered next cycle
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted request neither busy nor answered");

	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status != ST_OK) |-> rsp.frame_number == '0)
		else $error("frame number set on a failed request");

	a_nofree_region: assert property (@(posedge clk) disable iff (!arst_n)
		done && (rsp.status == ST_NOFREE || rsp.status == ST_OUTSIDE)
			|-> rsp.region_index == '0)
		else $error("region index set without a region");

	a_region_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> int'(rsp.region_index) < NUM_REGIONS)
		else $error("region index beyond region count");

endmodule

bind multi_region_page_frame_bitmap_allocator_unit pfba_checker u_pfba_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
